// File: sv/b64s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64s_pkg
// Shared types, codes and alphabet functions for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64s_pkg;

	// codec modes
	localparam logic MODE_ENCODE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;

	// decoder letter codes above the 6-bit range
	localparam logic [6:0] DEC_PAD = 7'd64;
	localparam logic [6:0] DEC_BAD = 7'd65;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// results released by one completed or flushed group
	typedef struct packed {
		logic [3:0][7:0] bytes;      // result k in bytes[k]
		logic [2:0]      count;      // 1 to 4
		logic            stream_end; // group closed by the final item
		logic            bad_char;   // decode group held an invalid character
	} b64s_bundle_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] idx);
		logic [7:0] w;
		begin
			w = {2'b00, idx};
			if (idx < 6'd26) begin
				return w + 8'd65;
			end else if (idx < 6'd52) begin
				return w + 8'd71;
			end else if (idx < 6'd62) begin
				return w - 8'd4;
			end else if (idx == 6'd62) begin
				return 8'h2B;
			end else begin
				return 8'h2F;
			end
		end
	endfunction

	// character to 6-bit value, DEC_PAD for '=', DEC_BAD otherwise
	function automatic logic [6:0] dec_val(input logic [7:0] c);
		logic [7:0] t;
		begin
			t = 8'd0;
			if (c >= 8'h41 && c <= 8'h5A) begin
				t = c - 8'd65;
				return t[6:0];
			end else if (c >= 8'h61 && c <= 8'h7A) begin
				t = c - 8'd71;
				return t[6:0];
			end else if (c >= 8'h30 && c <= 8'h39) begin
				t = c + 8'd4;
				return t[6:0];
			end else if (c == 8'h2B) begin
				return 7'd62;
			end else if (c == 8'h2F) begin
				return 7'd63;
			end else if (c == PAD_CHAR) begin
				return DEC_PAD;
			end else begin
				return DEC_BAD;
			end
		end
	endfunction

endpackage

// File: sv/b64s_group.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64s_group
// Group state and the single-pass encode / decode of one item.
// ----------------------------------------------------------------------------
module b64s_group import b64s_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         mode,
	input  logic         clear,
	input  logic         take,
	input  logic [7:0]   data_byte,
	input  logic         last_item,
	output logic         done,
	output b64s_bundle_t bundle
);

	logic [23:0] bits_q;
	logic [1:0]  count_q;
	logic [1:0]  pad_q;
	logic        err_q;

	logic [23:0] bits_n;
	logic [1:0]  pad_n;
	logic        err_n;
	logic [2:0]  pos1;
	logic [1:0]  pad_f;
	logic [6:0]  v;
	logic [5:0]  v6;
	logic [1:0]  epos;

	always_comb begin
		bits_n = bits_q;
		pad_n  = pad_q;
		err_n  = err_q;
		pos1   = 3'd0;
		pad_f  = 2'd0;
		done   = 1'b0;
		v      = dec_val(data_byte);
		v6     = v[5:0];
		epos   = (count_q > 2'd2) ? 2'd2 : count_q;
		bundle = '0;
		if (mode == MODE_ENCODE) begin
			case (epos)
				2'd0:    bits_n[23:16] = bits_q[23:16] | data_byte;
				2'd1:    bits_n[15:8]  = bits_q[15:8] | data_byte;
				default: bits_n[7:0]   = bits_q[7:0] | data_byte;
			endcase
			pos1 = {1'b0, epos} + 3'd1;
			done = (pos1 == 3'd3) || last_item;
			bundle.bytes[0] = enc_char(bits_n[23:18]);
			bundle.bytes[1] = enc_char(bits_n[17:12]);
			bundle.bytes[2] = (pos1 >= 3'd2) ? enc_char(bits_n[11:6]) : PAD_CHAR;
			bundle.bytes[3] = (pos1 >= 3'd3) ? enc_char(bits_n[5:0]) : PAD_CHAR;
			bundle.count    = 3'd4;
		end else begin
			if (v == DEC_PAD) begin
				v6 = 6'd0;
				if (count_q == 2'd2) begin
					pad_n = 2'd2;
				end else if (count_q == 2'd3) begin
					if (pad_q == 2'd0) pad_n = 2'd1;
				end else begin
					err_n = 1'b1;
				end
			end else if (v == DEC_BAD) begin
				v6    = 6'd0;
				err_n = 1'b1;
			end
			case (count_q)
				2'd0:    bits_n[23:18] = bits_q[23:18] | v6;
				2'd1:    bits_n[17:12] = bits_q[17:12] | v6;
				2'd2:    bits_n[11:6]  = bits_q[11:6] | v6;
				default: bits_n[5:0]   = bits_q[5:0] | v6;
			endcase
			pos1 = {1'b0, count_q} + 3'd1;
			done = (pos1 == 3'd4) || last_item;
			pad_f = pad_n;
			if (pos1 <= 3'd2) begin
				pad_f = 2'd2;
			end else if (pos1 == 3'd3 && pad_n == 2'd0) begin
				pad_f = 2'd1;
			end
			if (pad_f > 2'd2) pad_f = 2'd2;
			bundle.bytes[0] = bits_n[23:16];
			bundle.bytes[1] = bits_n[15:8];
			bundle.bytes[2] = bits_n[7:0];
			bundle.bytes[3] = 8'd0;
			bundle.count    = 3'd3 - {1'b0, pad_f};
			bundle.bad_char = err_n;
		end
		bundle.stream_end = last_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			count_q <= '0;
			pad_q   <= '0;
			err_q   <= 1'b0;
		end else if (clear || (take && done)) begin
			bits_q  <= '0;
			count_q <= '0;
			pad_q   <= '0;
			err_q   <= 1'b0;
		end else if (take) begin
			bits_q  <= bits_n;
			count_q <= pos1[1:0];
			pad_q   <= pad_n;
			err_q   <= err_n;
		end
	end

endmodule

// File: sv/b64s_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64s_outq
// Result register: holds one bundle and hands it out a byte per transaction.
// ----------------------------------------------------------------------------
module b64s_outq import b64s_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  b64s_bundle_t bundle,
	output logic         can_load,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [7:0]   m_tdata,
	output logic         m_tlast,
	output logic [1:0]   m_tuser
);

	logic [3:0][7:0] bytes_q;
	logic [2:0]      rem_q;
	logic [1:0]      idx_q;
	logic            end_q;
	logic            bad_q;

	assign m_tvalid = (rem_q != 3'd0);
	assign m_tdata  = bytes_q[idx_q];
	assign m_tlast  = (rem_q == 3'd1);
	assign m_tuser  = {bad_q, end_q & m_tlast};
	// free now, or the last byte leaves this cycle
	assign can_load = (rem_q == 3'd0) || (m_tlast && m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.count;
			idx_q <= '0;
		end else if (m_tvalid && m_tready) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= bundle.bytes;
			end_q   <= bundle.stream_end;
			bad_q   <= bundle.bad_char;
		end
	end

endmodule

// File: sv/base64_stream_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec
// Base64 (standard alphabet) encoder / decoder on a byte stream.
// ----------------------------------------------------------------------------
//  channel | dir | data                      | side bits
//  --------+-----+---------------------------+--------------------------------
//  s_*     | in  | tdata[7:0] data_byte      | tlast = last_item
//  m_*     | out | tdata[7:0] out_byte       | tlast = run_last,
//          |     |                           | tuser[0] stream_end, [1] bad_char
//  cfg_*   | in  | cfg_data = codec_mode     | always ready
//
//  Each input transaction lands in the input register (_s1) and is folded
//  into the group from there; a group that completes or is flushed by
//  tlast loads its 1..4 result bytes into the result register at once.
//  The result register drains one byte per cycle while m_tready is high, so
//  throughput is bound by the output port. Items that do not close a group
//  pass while the result register is still draining; a closing item waits
//  in _s1 until the last byte of the previous bundle is taken.
//  Reset clears the mode (encode), the group and both registers' valids.
//  A mode write starts a new stream and clears the partial group.
// ----------------------------------------------------------------------------
module base64_stream_codec import b64s_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	// input stream
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	// result stream
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser,   // [0] stream_end, [1] bad_char
	// mode register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data
);

	logic         mode_q;
	logic         valid_s1;
	logic [7:0]   data_s1;
	logic         last_s1;

	logic         cfg_wr;
	logic         done;
	logic         can_load;
	logic         adv;
	logic         load;
	b64s_bundle_t bundle;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// the held item may advance unless it closes a group and the
	// result register is still busy
	assign adv      = valid_s1 && (!done || can_load);
	assign load     = adv && done;
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ENCODE;
		end else if (cfg_wr) begin
			mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	b64s_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.mode      (mode_q),
		.clear     (cfg_wr),
		.take      (adv),
		.data_byte (data_s1),
		.last_item (last_s1),
		.done      (done),
		.bundle    (bundle)
	);

	b64s_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.bundle   (bundle),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	// a loaded bundle is visible on the output next cycle
	a_load_shows : assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded bundle not presented");

	// bundle sizes per mode
	a_enc_count : assert property (@(posedge clk) disable iff (!arst_n)
		(load && mode_q == MODE_ENCODE) |-> bundle.count == 3'd4)
		else $error("encode bundle size");

	a_dec_count : assert property (@(posedge clk) disable iff (!arst_n)
		(load && mode_q == MODE_DECODE) |->
		(bundle.count == 3'd1 || bundle.count == 3'd2 || bundle.count == 3'd3))
		else $error("decode bundle size");

	// after the last byte of a bundle with nothing new loaded, output goes idle
	a_drain_idle : assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !load) |=> !m_tvalid)
		else $error("output valid after bundle drained");

endmodule

// File: test/base64_stream_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_test
// Self-checking bench for the Base64 stream codec. A behavioural predictor
// folds every accepted input transaction into its own group state and queues
// the characters or bytes due; each result transaction is compared field by
// field with the oldest entry. Directed encode and decode cases come first,
// then random streams under three sender / receiver idling patterns.
// ----------------------------------------------------------------------------
module base64_stream_codec_test;
	import b64s_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int LIMIT_NS      = 2_000_000;

	// alphabet plus pad, character 0 in the top byte
	localparam logic [8*65-1:0] ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/=";

	// where a '=' was seen in the decode group
	localparam logic [1:0] PAD_NONE   = 2'd0;
	localparam logic [1:0] PAD_FOURTH = 2'd1;
	localparam logic [1:0] PAD_THIRD  = 2'd2;

	typedef struct packed {
		logic [7:0] data;
		logic       run_last;
		logic       stream_end;
		logic       bad_char;
	} b64_out_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       s_tvalid  = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata   = 8'h00;  // [7:0] data_byte
	logic       s_tlast   = 1'b0;
	logic       m_tvalid;
	logic       m_tready  = 1'b0;
	logic [7:0] m_tdata;            // [7:0] out_byte
	logic       m_tlast;
	logic [1:0] m_tuser;            // [0] stream_end, [1] bad_char
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       cfg_data  = 1'b0;

	// predictor state
	logic        cur_mode = MODE_ENCODE;
	logic [23:0] grp_bits = '0;
	int          grp_cnt  = 0;
	logic [1:0]  pad_st   = PAD_NONE;
	logic        grp_err  = 1'b0;

	b64_out_t due_out[$];
	int       errors        = 0;
	int       items_sent    = 0;
	int       src_gap_pct   = 25;
	int       snk_stall_pct = 48;

	base64_stream_codec dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [7:0] alpha_char(input int i);
		return ALPHABET[8*(64-i) +: 8];
	endfunction

	// search the alphabet; index 64 is the pad, anything else is invalid
	function automatic logic [6:0] letter_code(input logic [7:0] c);
		for (int i = 0; i < 65; i++) begin
			if (alpha_char(i) == c) begin
				return 7'(i);
			end
		end
		return DEC_BAD;
	endfunction

	function automatic void clear_group();
		grp_bits = '0;
		grp_cnt  = 0;
		pad_st   = PAD_NONE;
		grp_err  = 1'b0;
	endfunction

	// fold one accepted byte into the group, queue whatever it releases
	task automatic fold_b64(input logic [7:0] b, input logic last);
		int         pos;
		int         n;
		int         idx[4];
		logic [6:0] v;
		logic [1:0] pad;
		b64_out_t   r;
		pos = grp_cnt;
		if (cur_mode == MODE_ENCODE) begin
			if (pos > 2) pos = 2;
			grp_bits = grp_bits | ({16'd0, b} << (16 - 8*pos));
			pos++;
			if (pos < 3 && !last) begin
				grp_cnt = pos;
				return;
			end
			idx[0] = int'(grp_bits[23:18]);
			idx[1] = int'(grp_bits[17:12]);
			idx[2] = (pos >= 2) ? int'(grp_bits[11:6]) : 64;
			idx[3] = (pos >= 3) ? int'(grp_bits[5:0]) : 64;
			for (int k = 0; k < 4; k++) begin
				r.data       = alpha_char(idx[k]);
				r.run_last   = (k == 3);
				r.stream_end = last && (k == 3);
				r.bad_char   = 1'b0;
				due_out.push_back(r);
			end
		end else begin
			v = letter_code(b);
			if (v == DEC_PAD) begin
				v = '0;
				// pad only counts in the two tail places
				if (pos == 2) begin
					pad_st = PAD_THIRD;
				end else if (pos == 3) begin
					if (pad_st == PAD_NONE) pad_st = PAD_FOURTH;
				end else begin
					grp_err = 1'b1;
				end
			end else if (v == DEC_BAD) begin
				v = '0;
				grp_err = 1'b1;
			end
			grp_bits = grp_bits | ({18'd0, v[5:0]} << (18 - 6*pos));
			pos++;
			if (pos < 4 && !last) begin
				grp_cnt = pos;
				return;
			end
			// truncated groups: one or two places give a byte, three give two (one if padded)
			pad = pad_st;
			if (pos <= 2) pad = PAD_THIRD;
			else if (pos == 3 && pad == PAD_NONE) pad = PAD_FOURTH;
			n = 3 - int'(pad);
			for (int k = 0; k < n; k++) begin
				r.data       = grp_bits[16-8*k +: 8];
				r.run_last   = (k == n - 1);
				r.stream_end = last && (k == n - 1);
				r.bad_char   = grp_err;
				due_out.push_back(r);
			end
		end
		clear_group();
	endtask

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= snk_stall_pct);
	end

	// result checker
	always @(posedge clk) begin
		b64_out_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (due_out.size() == 0) begin
				$display("%0t: result with nothing due, actual tdata %h tlast %b tuser %b",
					$time, m_tdata, m_tlast, m_tuser);
				errors++;
			end else begin
				e = due_out.pop_front();
				if (m_tdata !== e.data) begin
					$display("%0t: out_byte expected %h actual %h", $time, e.data, m_tdata);
					errors++;
				end
				if (m_tlast !== e.run_last) begin
					$display("%0t: run_last expected %b actual %b",
						$time, e.run_last, m_tlast);
					errors++;
				end
				if (m_tuser[0] !== e.stream_end) begin
					$display("%0t: stream_end expected %b actual %b",
						$time, e.stream_end, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.bad_char) begin
					$display("%0t: bad_char expected %b actual %b",
						$time, e.bad_char, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// one input transaction, with a random gap in front of it
	task automatic send_item(input logic [7:0] d, input logic l);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= l;
		do @(posedge clk); while (!s_tready);
		fold_b64(d, l);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_item(s[i], i == s.len() - 1);
		end
	endtask

	// sender holds off until every due result has come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (due_out.size() != 0);
	endtask

	// a closing-free item may still be in flight, give it time to land
	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= m;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
		clear_group();
	endtask

	// random bytes, leaning on the extremes; an open end is left now and then
	task automatic enc_stream();
		int         len;
		logic       close;
		logic [7:0] b;
		len   = $urandom_range(1, 9);
		close = ($urandom_range(7) != 0);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(3) == 0) b = $urandom_range(1) ? 8'hFF : 8'h00;
			else b = 8'($urandom_range(255));
			send_item(b, close && (i == len - 1));
		end
	endtask

	// mostly well-formed groups; padding, noise and truncation mixed in
	task automatic dec_stream();
		int         ngroups;
		int         kind;
		int         nchar;
		logic       fin;
		logic [7:0] c[4];
		ngroups = $urandom_range(1, 3);
		for (int g = 0; g < ngroups; g++) begin
			fin   = (g == ngroups - 1);
			kind  = $urandom_range(9);
			nchar = 4;
			for (int i = 0; i < 4; i++) c[i] = alpha_char($urandom_range(63));
			case (kind)
				6: begin
					c[3] = PAD_CHAR;
				end
				7: begin
					c[2] = PAD_CHAR;
					c[3] = PAD_CHAR;
				end
				8: begin
					for (int i = 0; i < 4; i++) begin
						case ($urandom_range(2))
							0: c[i] = 8'($urandom_range(255));
							1: c[i] = PAD_CHAR;
							default: c[i] = alpha_char($urandom_range(63));
						endcase
					end
				end
				9: begin
					if (fin) begin
						nchar = $urandom_range(1, 3);
						if (nchar == 3 && $urandom_range(1)) c[2] = PAD_CHAR;
					end
				end
				default: begin
				end
			endcase
			for (int i = 0; i < nchar; i++) begin
				send_item(c[i], fin && (i == nchar - 1));
			end
		end
	endtask

	// encode straight out of reset: full group, one-pad and two-pad tails
	task automatic test_encode_directed();
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b1);
		send_item(8'hFF, 1'b1);
		send_item(8'hFB, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'hBF, 1'b1);
	endtask

	// pad in the fourth place, pad in the third place followed by junk,
	// misplaced pad and invalid bytes, truncated tails of three, one and two
	task automatic test_decode_directed();
		write_mode(MODE_DECODE);
		send_text("+/9=Qz=\377=\200Az");
		send_text("Zm9");
		send_text("Q");
		send_text("a=");
	endtask

	task automatic test_random_phase(input int gap_pct, input int stall_pct, input int n_items);
		int stop;
		src_gap_pct   = gap_pct;
		snk_stall_pct = stall_pct;
		stop = items_sent + n_items;
		write_mode(MODE_ENCODE);
		while (items_sent < stop - n_items / 2) begin
			enc_stream();
			if ($urandom_range(5) == 0) wait_drained();
		end
		write_mode(MODE_DECODE);
		while (items_sent < stop) begin
			dec_stream();
			if ($urandom_range(5) == 0) wait_drained();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_encode_directed();
		test_decode_directed();
		test_random_phase(25, 48, 85);
		test_random_phase(48, 25, 85);
		test_random_phase(0, 0, 90);
		settle();
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule

// File: files.f
sv/b64s_pkg.sv
sv/b64s_group.sv
sv/b64s_outq.sv
sv/base64_stream_codec.sv
test/base64_stream_codec_test.sv
